// ----- rtl/core/wgft_pkg.sv -----
// ----------------------------------------------------------------------------
// wgft_pkg
// shared types and constants of the flow peer tracker
// ----------------------------------------------------------------------------
`default_nettype none

package wgft_pkg;

   localparam int LENGTH_WIDTH     = 16;
   localparam int TYPE_WIDTH       = 8;
   localparam int RESERVED_WIDTH   = 24;
   localparam int INDEX_WIDTH      = 32;
   localparam int COUNT_WIDTH      = 32;
   localparam int CSR_INDEX_WIDTH  = 2;
   localparam int CSR_DATA_WIDTH   = 16;
   localparam int DATA_ALIGN_BITS  = 4;

   localparam logic [TYPE_WIDTH-1:0] TYPE_INITIATION = 8'd1;
   localparam logic [TYPE_WIDTH-1:0] TYPE_RESPONSE   = 8'd2;
   localparam logic [TYPE_WIDTH-1:0] TYPE_COOKIE     = 8'd3;
   localparam logic [TYPE_WIDTH-1:0] TYPE_DATA       = 8'd4;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_INIT_LENGTH     = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_RESPONSE_LENGTH = 2'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_COOKIE_LENGTH   = 2'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_MIN_DATA_LENGTH = 2'd3;

   localparam logic [LENGTH_WIDTH-1:0] INIT_LENGTH_RESET     = 16'd148;
   localparam logic [LENGTH_WIDTH-1:0] RESPONSE_LENGTH_RESET = 16'd92;
   localparam logic [LENGTH_WIDTH-1:0] COOKIE_LENGTH_RESET   = 16'd64;
   localparam logic [LENGTH_WIDTH-1:0] MIN_DATA_LENGTH_RESET = 16'd32;

   typedef struct packed {
      logic                      new_flow;
      logic                      is_udp;
      logic                      from_source;
      logic [LENGTH_WIDTH-1:0]   payload_bytes;
      logic [TYPE_WIDTH-1:0]     msg_type;
      logic [RESERVED_WIDTH-1:0] reserved_bytes;
      logic [INDEX_WIDTH-1:0]    first_index;
      logic [INDEX_WIDTH-1:0]    second_index;
   } req_payload_type;

   typedef struct packed {
      logic                   accepted;
      logic                   flush_flow;
      logic                   record_present;
      logic [INDEX_WIDTH-1:0] source_peer_out;
      logic [INDEX_WIDTH-1:0] dest_peer_out;
      logic [COUNT_WIDTH-1:0] packets_seen_out;
      logic [COUNT_WIDTH-1:0] packets_matched_out;
   } rsp_payload_type;

   typedef struct packed {
      logic [LENGTH_WIDTH-1:0] init_length;
      logic [LENGTH_WIDTH-1:0] response_length;
      logic [LENGTH_WIDTH-1:0] cookie_length;
      logic [LENGTH_WIDTH-1:0] min_data_length;
   } cfg_type;

   typedef struct packed {
      logic                   record_valid;
      logic [INDEX_WIDTH-1:0] source_peer;
      logic [INDEX_WIDTH-1:0] dest_peer;
      logic [COUNT_WIDTH-1:0] packets_seen;
      logic [COUNT_WIDTH-1:0] packets_matched;
   } flow_state_type;

endpackage

`default_nettype wire

// ----- rtl/core/wgft_if.sv -----
// ----------------------------------------------------------------------------
// wgft_req_if / wgft_rsp_if
// valid/ready channels of the flow peer tracker
// ----------------------------------------------------------------------------
`default_nettype none

interface wgft_req_if;
   logic                     valid;
   logic                     ready;
   wgft_pkg::req_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

interface wgft_rsp_if;
   logic                     valid;
   logic                     ready;
   wgft_pkg::rsp_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/wgft_classifier.sv -----
// ----------------------------------------------------------------------------
// wgft_classifier
// header checks and peer update for one packet against the flow state
// ----------------------------------------------------------------------------
`default_nettype none

module wgft_classifier (
   input  wire wgft_pkg::cfg_type         cfg,
   input  wire wgft_pkg::flow_state_type  state_cur,
   input  wire wgft_pkg::req_payload_type pkt,
   output wgft_pkg::flow_state_type       state_next,
   output wgft_pkg::rsp_payload_type      result
);
   import wgft_pkg::*;

   logic                   parse;
   logic                   header_ok;
   logic                   length_ok;
   logic                   conflict;
   logic                   accept;
   logic                   flush;
   logic [INDEX_WIDTH-1:0] base_src;
   logic [INDEX_WIDTH-1:0] base_dst;
   logic [INDEX_WIDTH-1:0] own_peer;
   logic [INDEX_WIDTH-1:0] new_src;
   logic [INDEX_WIDTH-1:0] new_dst;

   always_comb begin
      parse    = pkt.new_flow ? pkt.is_udp : state_cur.record_valid;
      base_src = pkt.new_flow ? '0 : state_cur.source_peer;
      base_dst = pkt.new_flow ? '0 : state_cur.dest_peer;
      own_peer = pkt.from_source ? base_src : base_dst;
      conflict = (own_peer != '0) && (own_peer != pkt.first_index);

      header_ok = (pkt.payload_bytes >= cfg.min_data_length)
               && (pkt.reserved_bytes == '0);

      new_src   = base_src;
      new_dst   = base_dst;
      length_ok = 1'b0;
      case (pkt.msg_type)
         TYPE_INITIATION: begin
            length_ok = (pkt.payload_bytes == cfg.init_length);
            if (pkt.from_source) begin
               new_src = pkt.first_index;
            end else begin
               new_dst = pkt.first_index;
            end
         end
         TYPE_RESPONSE: begin
            length_ok = (pkt.payload_bytes == cfg.response_length);
            new_src   = pkt.from_source ? pkt.first_index : pkt.second_index;
            new_dst   = pkt.from_source ? pkt.second_index : pkt.first_index;
         end
         TYPE_COOKIE: begin
            length_ok = (pkt.payload_bytes == cfg.cookie_length);
            if (pkt.from_source) begin
               new_dst = pkt.first_index;
            end else begin
               new_src = pkt.first_index;
            end
         end
         TYPE_DATA: begin
            length_ok = (pkt.payload_bytes[DATA_ALIGN_BITS-1:0] == '0);
            if (pkt.from_source) begin
               new_dst = pkt.first_index;
            end else begin
               new_src = pkt.first_index;
            end
         end
         default: begin
            length_ok = 1'b0;
         end
      endcase

      // an initiation naming another peer is refused and asks for a flush
      flush  = parse && header_ok && length_ok && (pkt.msg_type == TYPE_INITIATION)
            && conflict && !pkt.new_flow;
      accept = parse && header_ok && length_ok
            && !((pkt.msg_type == TYPE_INITIATION) && conflict);

      state_next.record_valid    = pkt.new_flow ? accept : state_cur.record_valid;
      state_next.source_peer     = accept ? new_src : base_src;
      state_next.dest_peer       = accept ? new_dst : base_dst;
      state_next.packets_seen    = state_cur.packets_seen + COUNT_WIDTH'(parse);
      state_next.packets_matched = state_cur.packets_matched + COUNT_WIDTH'(accept);

      result.accepted            = accept;
      result.flush_flow          = flush;
      result.record_present      = state_next.record_valid;
      result.source_peer_out     = state_next.source_peer;
      result.dest_peer_out       = state_next.dest_peer;
      result.packets_seen_out    = state_next.packets_seen;
      result.packets_matched_out = state_next.packets_matched;
   end

endmodule

`default_nettype wire

// ----- rtl/core/wireguard_flow_peer_tracker_top.sv -----
// ----------------------------------------------------------------------------
// wireguard_flow_peer_tracker_top
// per-flow message header classifier and peer index tracker
//
//  channel  direction  transfer
//  req_     in         one header summary per packet, valid/ready
//  rsp_     out        one verdict with peers and counters, valid/ready
//  csr_     in         length register write, no handshake
//
// one packet per cycle sustained unless rsp stalls; rsp valid follows the req
// transfer (input register, then classify and state update into result register)
// reset clears the flow state and the counters and reloads the length defaults
// a stalled rsp holds the result; req is taken while the input stage is empty
// or moves on in the same cycle
// ----------------------------------------------------------------------------
`default_nettype none

module wireguard_flow_peer_tracker_top (
   input  wire                                       clock,
   input  wire                                       reset,
   wgft_req_if.sink                                  req_chan,
   wgft_rsp_if.source                                rsp_chan,
   input  wire                                       csr_write_enable,
   input  wire [wgft_pkg::CSR_INDEX_WIDTH-1:0]       csr_index,
   input  wire [wgft_pkg::CSR_DATA_WIDTH-1:0]        csr_write_data
);
   import wgft_pkg::*;

   logic            in_valid_ff;
   logic            in_valid_in;
   req_payload_type in_payload_ff;
   logic            out_valid_ff;
   logic            out_valid_in;
   rsp_payload_type out_payload_ff;
   flow_state_type  state_ff;
   flow_state_type  state_in;
   cfg_type         cfg_ff;
   rsp_payload_type result;
   logic            advance;
   logic            req_take;

   wgft_classifier u_classifier (
      .cfg        (cfg_ff),
      .state_cur  (state_ff),
      .pkt        (in_payload_ff),
      .state_next (state_in),
      .result     (result)
   );

   assign advance        = in_valid_ff && (!out_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !in_valid_ff || advance;
   assign req_take       = req_chan.valid && req_chan.ready;

   always_comb begin
      in_valid_in  = req_take || (in_valid_ff && !advance);
      out_valid_in = advance || (out_valid_ff && !rsp_chan.ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         state_ff     <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (advance) begin
            state_ff <= state_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_payload_ff <= req_chan.payload;
      end
      if (advance) begin
         out_payload_ff <= result;
      end
   end

   // length registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.init_length     <= INIT_LENGTH_RESET;
         cfg_ff.response_length <= RESPONSE_LENGTH_RESET;
         cfg_ff.cookie_length   <= COOKIE_LENGTH_RESET;
         cfg_ff.min_data_length <= MIN_DATA_LENGTH_RESET;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_INIT_LENGTH:     cfg_ff.init_length     <= csr_write_data;
            CSR_RESPONSE_LENGTH: cfg_ff.response_length <= csr_write_data;
            CSR_COOKIE_LENGTH:   cfg_ff.cookie_length   <= csr_write_data;
            CSR_MIN_DATA_LENGTH: cfg_ff.min_data_length <= csr_write_data;
            default: begin
            end
         endcase
      end
   end

   assign rsp_chan.valid   = out_valid_ff;
   assign rsp_chan.payload = out_payload_ff;

   a_flush_not_accepted: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_payload_ff.flush_flow) |-> !out_payload_ff.accepted)
      else $error("flush raised on an accepted packet");

   a_flush_needs_record: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_payload_ff.flush_flow) |-> out_payload_ff.record_present)
      else $error("flush raised without a flow record");

   a_no_record_no_peers: assert property (@(posedge clock) disable iff (reset)
      !state_ff.record_valid |-> (state_ff.source_peer == '0 && state_ff.dest_peer == '0))
      else $error("peers held without a flow record");

   a_result_loaded: assert property (@(posedge clock) disable iff (reset)
      advance |=> out_valid_ff)
      else $error("classified packet lost before result register");

endmodule

`default_nettype wire
